>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define CHK_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define CHK_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/xdc_pkg.sv
// Types and constants of the distance constraint unit
package xdc_pkg;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_SOLVE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		UOP_MUL  = 2'd0,
		UOP_DIV  = 2'd1,
		UOP_SQRT = 2'd2
	} uop_t;

	typedef struct packed {
		logic start;
		uop_t op;
	} unit_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_IDX,
		ST_DISPATCH,
		ST_WR,
		ST_RD_A,
		ST_RD_CAP,
		ST_RD_B,
		ST_CAP_B,
		ST_DIFF,
		ST_MUL_DX,
		ST_MUL_DY,
		ST_SQRT,
		ST_LEN_CHK,
		ST_DIV_X,
		ST_DIV_Y,
		ST_MUL_ALPHA,
		ST_DENOM,
		ST_MUL_LAM,
		ST_NUM_MAG,
		ST_DIV_DL,
		ST_LAM,
		ST_MUL_P1,
		ST_MUL_P2,
		ST_MUL_TX1,
		ST_MUL_TY1,
		ST_MUL_TX2,
		ST_MUL_TY2,
		ST_WR_B,
		ST_WR_A,
		ST_OUT
	} state_t;

	localparam int unsigned INDEX_BITS = 10;
	localparam logic [31:0] INV_DT_RESET = 32'h0001_0000;

	localparam int unsigned OPA_W = 65;
	localparam int unsigned OPB_W = 34;
	localparam int unsigned RES_W = 80;

	localparam logic [6:0] MUL_LAST  = 7'd31;
	localparam logic [6:0] DIV_LAST  = 7'd63;
	localparam logic [6:0] SQRT_LAST = 7'd32;

endpackage

>>> hw/rtl/xdc_serial_unit.sv
// Bit-serial multiplier, restoring divider and square root sharing one sequencer
`include "assert_macros.svh"

module xdc_serial_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  xdc_pkg::unit_req_t            req,
	input  logic [xdc_pkg::OPA_W-1:0]     opa,
	input  logic [xdc_pkg::OPB_W-1:0]     opb,
	output logic                          done,
	output logic [xdc_pkg::RES_W-1:0]     result
);

	logic          busy_q;
	logic          done_q;
	logic [6:0]    cnt_q;
	xdc_pkg::uop_t op_q;

	logic [79:0] prod_q;
	logic [47:0] mcand_q;
	logic [63:0] quot_q;
	logic [33:0] rem_q;
	logic [33:0] dsr_q;
	logic [65:0] rad_q;
	logic [36:0] srem_q;
	logic [32:0] root_q;

	logic [48:0] mul_sum;
	logic [34:0] div_r;
	logic        div_ge;
	logic [34:0] div_diff;
	logic [36:0] sq_t;
	logic [36:0] sq_trial;
	logic        sq_ge;
	logic [36:0] sq_diff;

	always_comb begin
		mul_sum  = {1'b0, prod_q[79:32]} + (prod_q[0] ? {1'b0, mcand_q} : 49'd0);
		div_r    = {rem_q, quot_q[63]};
		div_ge   = (div_r >= {1'b0, dsr_q});
		div_diff = div_r - {1'b0, dsr_q};
		sq_t     = {srem_q[34:0], rad_q[65:64]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_ge    = (sq_t >= sq_trial);
		sq_diff  = sq_t - sq_trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= xdc_pkg::UOP_MUL;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			op_q   <= req.op;
			case (req.op)
				xdc_pkg::UOP_DIV:  cnt_q <= xdc_pkg::DIV_LAST;
				xdc_pkg::UOP_SQRT: cnt_q <= xdc_pkg::SQRT_LAST;
				default:           cnt_q <= xdc_pkg::MUL_LAST;
			endcase
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 7'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_q  <= {48'd0, opb[31:0]};
			mcand_q <= opa[47:0];
			quot_q  <= opa[63:0];
			rem_q   <= '0;
			dsr_q   <= opb;
			rad_q   <= {1'b0, opa};
			srem_q  <= '0;
			root_q  <= '0;
		end else if (busy_q) begin
			case (op_q)
				xdc_pkg::UOP_MUL: begin
					prod_q <= {mul_sum, prod_q[31:1]};
				end
				xdc_pkg::UOP_DIV: begin
					rem_q  <= div_ge ? div_diff[33:0] : div_r[33:0];
					quot_q <= {quot_q[62:0], div_ge};
				end
				xdc_pkg::UOP_SQRT: begin
					srem_q <= sq_ge ? sq_diff : sq_t;
					root_q <= {root_q[31:0], sq_ge};
					rad_q  <= {rad_q[63:0], 2'b00};
				end
				default: begin
					prod_q <= prod_q;
				end
			endcase
		end
	end

	always_comb begin
		case (op_q)
			xdc_pkg::UOP_DIV:  result = {16'd0, quot_q};
			xdc_pkg::UOP_SQRT: result = {47'd0, root_q};
			default:           result = prod_q;
		endcase
	end

	assign done = done_q;

	`CHK_NXT(a_start_busy, clk, arst_n, req.start, busy_q, "unit not busy after start")
	`CHK_IMP(a_done_idle, clk, arst_n, done_q, !busy_q, "unit done while busy")
	`CHK_NXT(a_done_pulse, clk, arst_n, done_q, !done_q, "unit done longer than one cycle")

endmodule

>>> hw/rtl/xpbd_distance_constraint_unit.sv
// Top level of the distance constraint unit: point store, sequencer and result register
//
//  channel   direction  handshake              payload
//  cfg       in         cfg_wr_en              cfg_wr_data (1/dt^2)
//  in        in         in_valid / in_stall    action .. lambda_in
//  out       out        out_valid / out_stall  out_x .. saturated
//
//  Every transaction first reduces both point indices modulo the store depth.
//  A full solve transaction runs ten multiplies, a square root and three divides on the
//  serial unit, one bit per cycle.
//  Reset clears the sequencer and the output valid and sets 1/dt^2 to 1.0; store undefined.
//  A stalled result holds in the output register; the next transaction runs meanwhile
//  and waits at its end for the register to free.
`include "assert_macros.svh"

module xpbd_distance_constraint_unit #(
	parameter int POINTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [9:0]         first_index,
	input  logic [9:0]         second_index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [31:0]        inv_mass,
	input  logic [30:0]        rest_length,
	input  logic [31:0]        compliance,
	input  logic signed [31:0] lambda_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic [31:0]        out_inv_mass,
	output logic signed [31:0] lambda_out,
	output logic               skipped,
	output logic               saturated
);

	localparam int AW = $clog2(POINTS);
	localparam logic [AW:0] PTS = (AW+1)'(POINTS);

	function automatic logic [32:0] sat_s32(input logic [51:0] v);
		logic [32:0] r;
		if (!v[51] && (v[50:31] != 20'd0)) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v[51] && (v[50:31] != 20'hFFFFF)) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	xdc_pkg::state_t    state_q, state_d;
	logic               started_q;
	logic [3:0]         idx_cnt_q;
	logic [31:0]        inv_dt_q;
	logic               out_valid_q;

	xdc_pkg::unit_req_t ureq;
	logic [xdc_pkg::OPA_W-1:0] uopa;
	logic [xdc_pkg::OPB_W-1:0] uopb;
	logic               unit_done;
	logic [xdc_pkg::RES_W-1:0] uresult;

	logic [95:0]        mem [POINTS];
	logic [95:0]        rd_data_q;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [95:0]        mem_wdata;

	xdc_pkg::action_t   act_q;
	logic [9:0]         ia_q, ib_q;
	logic [AW-1:0]      ra_q, rb_q;
	logic [31:0]        px_q, py_q, pw_q;
	logic [30:0]        rest_q;
	logic [31:0]        comp_q, lam_q;
	logic [31:0]        x1_q, y1_q, w1_q, x2_q, y2_q, w2_q;
	logic               dxn_q, dyn_q;
	logic [31:0]        mdx_q, mdy_q;
	logic [64:0]        sum_q;
	logic [32:0]        len_q;
	logic [16:0]        gxm_q, gym_q;
	logic [31:0]        alpha_q;
	logic               sat_q;
	logic [33:0]        denom_q;
	logic [34:0]        t_q;
	logic [50:0]        numer_q;
	logic               neg_q;
	logic [47:0]        nmag_q;
	logic [31:0]        dl_q, dlm_q;
	logic [47:0]        p1_q, p2_q;
	logic [31:0]        nx1_q, ny1_q, nx2_q, ny2_q;
	logic [31:0]        res_x_q, res_y_q, res_w_q, res_lam_q;
	logic               res_skip_q, res_sat_q;
	logic [31:0]        out_x_q, out_y_q, out_w_q, out_lam_q;
	logic               out_skip_q, out_sat_q;

	logic               accept;
	logic               out_load;
	logic [AW:0]        ra_shift, rb_shift, ra_next, rb_next;
	logic [32:0]        dx_c, dy_c;
	logic [31:0]        lam_mag;
	logic [50:0]        numer_c;
	logic [50:0]        nneg_c;
	logic               big_neg, big_pos;
	logic [32:0]        lam_sum;
	logic [32:0]        lam_sat;
	logic [51:0]        pos_t, pos_v;
	logic [31:0]        pos_base;
	logic               pos_neg;
	logic [32:0]        pos_sat;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != xdc_pkg::ST_IDLE);
	assign out_load = (state_q == xdc_pkg::ST_OUT) && (!out_valid_q || !out_stall);

	xdc_serial_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.opa    (uopa),
		.opb    (uopb),
		.done   (unit_done),
		.result (uresult)
	);

	always_comb begin
		ra_shift = {ra_q, ia_q[xdc_pkg::INDEX_BITS-1]};
		rb_shift = {rb_q, ib_q[xdc_pkg::INDEX_BITS-1]};
		ra_next  = (ra_shift >= PTS) ? ra_shift - PTS : ra_shift;
		rb_next  = (rb_shift >= PTS) ? rb_shift - PTS : rb_shift;
		dx_c     = {x1_q[31], x1_q} - {x2_q[31], x2_q};
		dy_c     = {y1_q[31], y1_q} - {y2_q[31], y2_q};
		lam_mag  = lam_q[31] ? (32'd0 - lam_q) : lam_q;
		numer_c  = {{16{t_q[34]}}, t_q}
			+ (lam_q[31] ? {3'd0, uresult[63:16]} : (51'd0 - {3'd0, uresult[63:16]}));
		nneg_c   = 51'd0 - numer_q;
		big_neg  = (uresult[63:32] != 32'd0) || (uresult[31] && (uresult[30:0] != 31'd0));
		big_pos  = (uresult[63:31] != 33'd0);
		lam_sum  = {lam_q[31], lam_q} + {dl_q[31], dl_q};
		lam_sat  = sat_s32({{19{lam_sum[32]}}, lam_sum});
		case (state_q)
			xdc_pkg::ST_MUL_TY1: begin
				pos_base = y1_q;
				pos_neg  = neg_q ^ dyn_q;
			end
			xdc_pkg::ST_MUL_TX2: begin
				pos_base = x2_q;
				pos_neg  = !(neg_q ^ dxn_q);
			end
			xdc_pkg::ST_MUL_TY2: begin
				pos_base = y2_q;
				pos_neg  = !(neg_q ^ dyn_q);
			end
			default: begin
				pos_base = x1_q;
				pos_neg  = neg_q ^ dxn_q;
			end
		endcase
		pos_t   = {4'd0, uresult[63:16]};
		pos_v   = {{20{pos_base[31]}}, pos_base} + (pos_neg ? (52'd0 - pos_t) : pos_t);
		pos_sat = sat_s32(pos_v);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xdc_pkg::ST_IDLE;
			started_q   <= 1'b0;
			idx_cnt_q   <= '0;
			inv_dt_q    <= xdc_pkg::INV_DT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ureq.start) begin
				started_q <= 1'b1;
			end else if (unit_done) begin
				started_q <= 1'b0;
			end
			if (accept) begin
				idx_cnt_q <= '0;
			end else if (state_q == xdc_pkg::ST_IDX) begin
				idx_cnt_q <= idx_cnt_q + 4'd1;
			end
			if (cfg_wr_en) begin
				inv_dt_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		ureq      = '{start: 1'b0, op: xdc_pkg::UOP_MUL};
		uopa      = '0;
		uopb      = '0;
		mem_we    = 1'b0;
		mem_waddr = ra_q;
		mem_wdata = {px_q, py_q, pw_q};
		mem_raddr = ra_q;
		case (state_q)
			xdc_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = xdc_pkg::ST_IDX;
				end
			end
			xdc_pkg::ST_IDX: begin
				if (idx_cnt_q == 4'(xdc_pkg::INDEX_BITS - 1)) begin
					state_d = xdc_pkg::ST_DISPATCH;
				end
			end
			xdc_pkg::ST_DISPATCH: begin
				case (act_q)
					xdc_pkg::ACT_WRITE: state_d = xdc_pkg::ST_WR;
					xdc_pkg::ACT_READ:  state_d = xdc_pkg::ST_RD_A;
					xdc_pkg::ACT_SOLVE: state_d = xdc_pkg::ST_RD_A;
					default:            state_d = xdc_pkg::ST_OUT;
				endcase
			end
			xdc_pkg::ST_WR: begin
				mem_we  = 1'b1;
				state_d = xdc_pkg::ST_OUT;
			end
			xdc_pkg::ST_RD_A: begin
				state_d = (act_q == xdc_pkg::ACT_READ) ? xdc_pkg::ST_RD_CAP : xdc_pkg::ST_RD_B;
			end
			xdc_pkg::ST_RD_CAP: state_d = xdc_pkg::ST_OUT;
			xdc_pkg::ST_RD_B: begin
				mem_raddr = rb_q;
				state_d   = xdc_pkg::ST_CAP_B;
			end
			xdc_pkg::ST_CAP_B: state_d = xdc_pkg::ST_DIFF;
			xdc_pkg::ST_DIFF:  state_d = xdc_pkg::ST_MUL_DX;
			xdc_pkg::ST_MUL_DX: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_MUL};
				uopa = {33'd0, mdx_q};
				uopb = {2'd0, mdx_q};
				if (unit_done) state_d = xdc_pkg::ST_MUL_DY;
			end
			xdc_pkg::ST_MUL_DY: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_MUL};
				uopa = {33'd0, mdy_q};
				uopb = {2'd0, mdy_q};
				if (unit_done) state_d = xdc_pkg::ST_SQRT;
			end
			xdc_pkg::ST_SQRT: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_SQRT};
				uopa = sum_q;
				if (unit_done) state_d = xdc_pkg::ST_LEN_CHK;
			end
			xdc_pkg::ST_LEN_CHK: begin
				state_d = (len_q == 33'd0) ? xdc_pkg::ST_OUT : xdc_pkg::ST_DIV_X;
			end
			xdc_pkg::ST_DIV_X: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_DIV};
				uopa = {17'd0, mdx_q, 16'd0};
				uopb = {1'b0, len_q};
				if (unit_done) state_d = xdc_pkg::ST_DIV_Y;
			end
			xdc_pkg::ST_DIV_Y: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_DIV};
				uopa = {17'd0, mdy_q, 16'd0};
				uopb = {1'b0, len_q};
				if (unit_done) state_d = xdc_pkg::ST_MUL_ALPHA;
			end
			xdc_pkg::ST_MUL_ALPHA: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_MUL};
				uopa = {33'd0, comp_q};
				uopb = {2'd0, inv_dt_q};
				if (unit_done) state_d = xdc_pkg::ST_DENOM;
			end
			xdc_pkg::ST_DENOM: state_d = xdc_pkg::ST_MUL_LAM;
			xdc_pkg::ST_MUL_LAM: begin
				if (denom_q == 34'd0) begin
					state_d = xdc_pkg::ST_OUT;
				end else begin
					ureq = '{start: !started_q, op: xdc_pkg::UOP_MUL};
					uopa = {33'd0, alpha_q};
					uopb = {2'd0, lam_mag};
					if (unit_done) state_d = xdc_pkg::ST_NUM_MAG;
				end
			end
			xdc_pkg::ST_NUM_MAG: state_d = xdc_pkg::ST_DIV_DL;
			xdc_pkg::ST_DIV_DL: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_DIV};
				uopa = {1'b0, nmag_q, 16'd0};
				uopb = denom_q;
				if (unit_done) state_d = xdc_pkg::ST_LAM;
			end
			xdc_pkg::ST_LAM: state_d = xdc_pkg::ST_MUL_P1;
			xdc_pkg::ST_MUL_P1: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_MUL};
				uopa = {33'd0, w1_q};
				uopb = {2'd0, dlm_q};
				if (unit_done) state_d = xdc_pkg::ST_MUL_P2;
			end
			xdc_pkg::ST_MUL_P2: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_MUL};
				uopa = {33'd0, w2_q};
				uopb = {2'd0, dlm_q};
				if (unit_done) state_d = xdc_pkg::ST_MUL_TX1;
			end
			xdc_pkg::ST_MUL_TX1: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_MUL};
				uopa = {17'd0, p1_q};
				uopb = {17'd0, gxm_q};
				if (unit_done) state_d = xdc_pkg::ST_MUL_TY1;
			end
			xdc_pkg::ST_MUL_TY1: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_MUL};
				uopa = {17'd0, p1_q};
				uopb = {17'd0, gym_q};
				if (unit_done) state_d = xdc_pkg::ST_MUL_TX2;
			end
			xdc_pkg::ST_MUL_TX2: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_MUL};
				uopa = {17'd0, p2_q};
				uopb = {17'd0, gxm_q};
				if (unit_done) state_d = xdc_pkg::ST_MUL_TY2;
			end
			xdc_pkg::ST_MUL_TY2: begin
				ureq = '{start: !started_q, op: xdc_pkg::UOP_MUL};
				uopa = {17'd0, p2_q};
				uopb = {17'd0, gym_q};
				if (unit_done) state_d = xdc_pkg::ST_WR_B;
			end
			xdc_pkg::ST_WR_B: begin
				mem_we    = 1'b1;
				mem_waddr = rb_q;
				mem_wdata = {nx2_q, ny2_q, w2_q};
				state_d   = xdc_pkg::ST_WR_A;
			end
			xdc_pkg::ST_WR_A: begin
				mem_we    = 1'b1;
				mem_wdata = {nx1_q, ny1_q, w1_q};
				state_d   = xdc_pkg::ST_OUT;
			end
			xdc_pkg::ST_OUT: begin
				if (out_load) state_d = xdc_pkg::ST_IDLE;
			end
			default: state_d = xdc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			xdc_pkg::ST_IDLE: begin
				if (accept) begin
					act_q  <= xdc_pkg::action_t'(action);
					ia_q   <= first_index;
					ib_q   <= second_index;
					ra_q   <= '0;
					rb_q   <= '0;
					px_q   <= pos_x;
					py_q   <= pos_y;
					pw_q   <= inv_mass;
					rest_q <= rest_length;
					comp_q <= compliance;
					lam_q  <= lambda_in;
				end
			end
			xdc_pkg::ST_IDX: begin
				ra_q <= ra_next[AW-1:0];
				rb_q <= rb_next[AW-1:0];
				ia_q <= {ia_q[xdc_pkg::INDEX_BITS-2:0], 1'b0};
				ib_q <= {ib_q[xdc_pkg::INDEX_BITS-2:0], 1'b0};
			end
			xdc_pkg::ST_DISPATCH: begin
				res_x_q    <= '0;
				res_y_q    <= '0;
				res_w_q    <= '0;
				res_lam_q  <= '0;
				res_skip_q <= 1'b0;
				res_sat_q  <= 1'b0;
			end
			xdc_pkg::ST_WR: begin
				res_x_q <= px_q;
				res_y_q <= py_q;
				res_w_q <= pw_q;
			end
			xdc_pkg::ST_RD_CAP: begin
				res_x_q <= rd_data_q[95:64];
				res_y_q <= rd_data_q[63:32];
				res_w_q <= rd_data_q[31:0];
			end
			xdc_pkg::ST_RD_B: begin
				x1_q <= rd_data_q[95:64];
				y1_q <= rd_data_q[63:32];
				w1_q <= rd_data_q[31:0];
			end
			xdc_pkg::ST_CAP_B: begin
				x2_q <= rd_data_q[95:64];
				y2_q <= rd_data_q[63:32];
				w2_q <= rd_data_q[31:0];
			end
			xdc_pkg::ST_DIFF: begin
				dxn_q <= dx_c[32];
				dyn_q <= dy_c[32];
				mdx_q <= dx_c[32] ? (32'd0 - dx_c[31:0]) : dx_c[31:0];
				mdy_q <= dy_c[32] ? (32'd0 - dy_c[31:0]) : dy_c[31:0];
			end
			xdc_pkg::ST_MUL_DX: begin
				if (unit_done) sum_q <= {1'b0, uresult[63:0]};
			end
			xdc_pkg::ST_MUL_DY: begin
				if (unit_done) sum_q <= sum_q + {1'b0, uresult[63:0]};
			end
			xdc_pkg::ST_SQRT: begin
				if (unit_done) len_q <= uresult[32:0];
			end
			xdc_pkg::ST_LEN_CHK: begin
				res_x_q    <= x1_q;
				res_y_q    <= y1_q;
				res_w_q    <= '0;
				res_lam_q  <= lam_q;
				res_skip_q <= 1'b1;
				res_sat_q  <= 1'b0;
			end
			xdc_pkg::ST_DIV_X: begin
				if (unit_done) gxm_q <= uresult[16:0];
			end
			xdc_pkg::ST_DIV_Y: begin
				if (unit_done) gym_q <= uresult[16:0];
			end
			xdc_pkg::ST_MUL_ALPHA: begin
				if (unit_done) begin
					sat_q   <= (uresult[63:48] != 16'd0);
					alpha_q <= (uresult[63:48] != 16'd0) ? 32'hFFFF_FFFF : uresult[47:16];
				end
			end
			xdc_pkg::ST_DENOM: begin
				denom_q <= {2'd0, w1_q} + {2'd0, w2_q} + {2'd0, alpha_q};
				t_q     <= {4'd0, rest_q} - {2'd0, len_q};
			end
			xdc_pkg::ST_MUL_LAM: begin
				res_sat_q <= sat_q;
				if (unit_done) numer_q <= numer_c;
			end
			xdc_pkg::ST_NUM_MAG: begin
				neg_q  <= numer_q[50];
				nmag_q <= numer_q[50] ? nneg_c[47:0] : numer_q[47:0];
			end
			xdc_pkg::ST_DIV_DL: begin
				if (unit_done) begin
					if (neg_q) begin
						dl_q  <= big_neg ? 32'h8000_0000 : (32'd0 - uresult[31:0]);
						dlm_q <= big_neg ? 32'h8000_0000 : uresult[31:0];
						sat_q <= sat_q | big_neg;
					end else begin
						dl_q  <= big_pos ? 32'h7FFF_FFFF : uresult[31:0];
						dlm_q <= big_pos ? 32'h7FFF_FFFF : uresult[31:0];
						sat_q <= sat_q | big_pos;
					end
				end
			end
			xdc_pkg::ST_LAM: begin
				res_lam_q <= lam_sat[31:0];
				sat_q     <= sat_q | lam_sat[32];
			end
			xdc_pkg::ST_MUL_P1: begin
				if (unit_done) p1_q <= uresult[63:16];
			end
			xdc_pkg::ST_MUL_P2: begin
				if (unit_done) p2_q <= uresult[63:16];
			end
			xdc_pkg::ST_MUL_TX1: begin
				if (unit_done) begin
					nx1_q <= pos_sat[31:0];
					sat_q <= sat_q | pos_sat[32];
				end
			end
			xdc_pkg::ST_MUL_TY1: begin
				if (unit_done) begin
					ny1_q <= pos_sat[31:0];
					sat_q <= sat_q | pos_sat[32];
				end
			end
			xdc_pkg::ST_MUL_TX2: begin
				if (unit_done) begin
					nx2_q <= pos_sat[31:0];
					sat_q <= sat_q | pos_sat[32];
				end
			end
			xdc_pkg::ST_MUL_TY2: begin
				if (unit_done) begin
					ny2_q <= pos_sat[31:0];
					sat_q <= sat_q | pos_sat[32];
				end
			end
			xdc_pkg::ST_WR_A: begin
				res_x_q    <= nx1_q;
				res_y_q    <= ny1_q;
				res_w_q    <= '0;
				res_skip_q <= 1'b0;
				res_sat_q  <= sat_q;
			end
			xdc_pkg::ST_OUT: begin
				if (out_load) begin
					out_x_q    <= res_x_q;
					out_y_q    <= res_y_q;
					out_w_q    <= res_w_q;
					out_lam_q  <= res_lam_q;
					out_skip_q <= res_skip_q;
					out_sat_q  <= res_sat_q;
				end
			end
			default: begin
				sat_q <= sat_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign out_inv_mass = out_w_q;
	assign lambda_out   = out_lam_q;
	assign skipped      = out_skip_q;
	assign saturated    = out_sat_q;

	`CHK_NXT(a_accept_idx, clk, arst_n, accept, state_q == xdc_pkg::ST_IDX, "accept did not start index reduction")
	`CHK_IMP(a_index_range, clk, arst_n, state_q == xdc_pkg::ST_RD_A, ({1'b0, ra_q} < PTS) && ({1'b0, rb_q} < PTS), "point index beyond store")
	`CHK_IMP(a_no_done_idle, clk, arst_n, state_q == xdc_pkg::ST_IDLE, !unit_done, "serial unit done while idle")
	`CHK_IMP(a_skip_mass, clk, arst_n, out_valid_q && out_skip_q, out_w_q == 32'd0, "skipped result carries a mass")

endmodule
